// ----- design/bdas_pkg.sv -----
`default_nettype none

package bdas_pkg;

  localparam int OUT_SIZE  = 64;
  localparam int MAX_BLOCK = 64;
  localparam int WIDTH_MAX = 4096;
  localparam int QDEPTH    = 4;

  localparam int PIX_W    = 8;
  localparam int IW_W     = 13;
  localparam int BW_W     = 7;
  localparam int COL_W    = 12;
  localparam int ROW_W    = 6;
  localparam int BAND_W   = 7;
  localparam int CIB_W    = BW_W - 1;
  localparam int SUM_W    = 20;
  localparam int DIV_W    = 13;
  localparam int CHAR_W   = 7;
  localparam int BLK_W    = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
  localparam int PROD_W   = BLK_W + 1 + BW_W;
  localparam int SCNT_W   = $clog2(COL_W);
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = IW_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_W     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_H     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT      = 2'd3;

  localparam logic [IW_W-1:0] RST_IMAGE_WIDTH = 13'd80;
  localparam logic [BW_W-1:0] RST_BLOCK_W     = 7'd1;
  localparam logic [BW_W-1:0] RST_BLOCK_H     = 7'd1;

  localparam logic [PIX_W-1:0] PIX_MAX     = 8'd255;
  localparam logic [PIX_W-1:0] SHADE_FIRST = 8'd15;
  localparam logic [PIX_W-1:0] SHADE_LAST  = 8'd239;

  localparam logic [CHAR_W-1:0] SHADE_TABLE [16] = '{
    7'd36,  7'd64, 7'd37, 7'd87, 7'd77, 7'd35, 7'd42, 7'd99,
    7'd120, 7'd41, 7'd63, 7'd43, 7'd126, 7'd59, 7'd58, 7'd46
  };

  typedef struct packed {
    logic [IW_W-1:0] image_width;
    logic [BW_W-1:0] block_w;
    logic [BW_W-1:0] block_h;
    logic            invert;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [DIV_W-1:0] divisor;
    logic             row_end;
    logic             frame_end;
  } job_t;

  typedef enum logic [1:0] {F_IDLE, F_SYNC, F_UPD} front_state_t;
  typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} div_state_t;

  function automatic logic [CHAR_W-1:0] shade_of(input logic [PIX_W-1:0] v);
    logic [PIX_W-1:0] d;
    logic [3:0]       idx;
    d = v - SHADE_FIRST;
    if (v < SHADE_FIRST) begin
      idx = 4'd0;
    end else if (v >= SHADE_LAST) begin
      idx = 4'd15;
    end else begin
      idx = d[7:4] + 4'd1;
    end
    return SHADE_TABLE[idx];
  endfunction

endpackage

`default_nettype wire

// ----- design/bdas_if.sv -----
`default_nettype none

interface bdas_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;
  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface bdas_chr_if;
  logic       valid;
  logic       ready;
  logic [6:0] shade_char;
  logic       row_end;
  logic       frame_end;
  modport source (output valid, shade_char, row_end, frame_end, input ready);
  modport sink   (input valid, shade_char, row_end, frame_end, output ready);
endinterface

`default_nettype wire

// ----- design/bdas_front.sv -----
`default_nettype none

module bdas_front (
  input  logic           clk,
  input  logic           rst,
  input  bdas_pkg::cfg_t cfg,
  input  logic           resync,
  bdas_pix_if.sink       pix,
  input  logic           q_full,
  output logic           q_push,
  output bdas_pkg::job_t q_job
);
  import bdas_pkg::*;

  front_state_t state, state_next;

  logic [COL_W-1:0]  pixel_column, pixel_column_next;
  logic [ROW_W-1:0]  row_in_band, row_in_band_next;
  logic [BAND_W-1:0] band_index, band_index_next;
  logic              frame_done, frame_done_next;
  logic [COL_W-1:0]  blk, blk_next;
  logic [CIB_W-1:0]  cib, cib_next;
  logic              sync_req;
  logic [OUT_SIZE-1:0] valid;

  logic [SUM_W-1:0] sums [OUT_SIZE];
  logic [SUM_W-1:0] mem_q;

  logic [BLK_W-1:0] u_blk;
  logic [PIX_W-1:0] u_pix;
  logic             u_zero;
  logic             u_emit;
  logic             u_rend;
  logic             u_fend;
  logic [DIV_W-1:0] u_div;

  logic [COL_W-1:0] s_sh;
  logic [COL_W-1:0] s_q;
  logic [CIB_W-1:0] s_rem;
  logic [SCNT_W-1:0] s_cnt;

  logic [IW_W-1:0]   w_eff;
  logic [BW_W-1:0]   bw_eff;
  logic [BW_W-1:0]   bh_eff;
  logic              fs;
  logic [COL_W-1:0]  col_e;
  logic [ROW_W-1:0]  rib_e;
  logic [BAND_W-1:0] band_e;
  logic              fd_e;
  logic [COL_W-1:0]  blk_e;
  logic [CIB_W-1:0]  cib_e;
  logic [BLK_W-1:0]  blk_lo;
  logic [BLK_W:0]    blk_inc;
  logic [PROD_W-1:0] end_prod;
  logic [PROD_W:0]   end_next;
  logic [2*BW_W-1:0] div_prod;
  logic [BAND_W-1:0] band_inc;
  logic              in_grid;
  logic              blk_ok;
  logic              last_row;
  logic              blk_done;
  logic              emit;
  logic              rend;
  logic              fend;
  logic              col_wrap;
  logic              accept;
  logic              mem_rd;
  logic              mem_wr;
  logic              sync_start;
  logic              sync_last;
  logic [BW_W-1:0]   s_t;
  logic              s_ge;
  logic [CIB_W-1:0]  s_rem_new;
  logic [SUM_W-1:0]  u_sum;

  always_comb begin
    w_eff = cfg.image_width;
    if (cfg.image_width == '0) begin
      w_eff = 13'd1;
    end else if (cfg.image_width > IW_W'(WIDTH_MAX)) begin
      w_eff = IW_W'(WIDTH_MAX);
    end
    bw_eff = cfg.block_w;
    if (cfg.block_w == '0) begin
      bw_eff = 7'd1;
    end else if (cfg.block_w > BW_W'(MAX_BLOCK)) begin
      bw_eff = BW_W'(MAX_BLOCK);
    end
    bh_eff = cfg.block_h;
    if (cfg.block_h == '0) begin
      bh_eff = 7'd1;
    end else if (cfg.block_h > BW_W'(MAX_BLOCK)) begin
      bh_eff = BW_W'(MAX_BLOCK);
    end
  end

  assign fs     = pix.frame_start;
  assign col_e  = fs ? '0 : pixel_column;
  assign rib_e  = fs ? '0 : row_in_band;
  assign band_e = fs ? '0 : band_index;
  assign fd_e   = fs ? 1'b0 : frame_done;
  assign blk_e  = fs ? '0 : blk;
  assign cib_e  = fs ? '0 : cib;

  assign blk_lo   = blk_e[BLK_W-1:0];
  assign blk_inc  = {1'b0, blk_lo} + {{BLK_W{1'b0}}, 1'b1};
  assign end_prod = PROD_W'(blk_inc) * PROD_W'(bw_eff);
  assign end_next = {1'b0, end_prod} + (PROD_W+1)'(bw_eff);
  assign div_prod = (2*BW_W)'(bw_eff) * (2*BW_W)'(bh_eff);
  assign band_inc = band_e + 7'd1;

  assign in_grid  = blk_e < COL_W'(OUT_SIZE);
  assign blk_ok   = !fd_e && in_grid && (end_prod <= PROD_W'(w_eff));
  assign last_row = ({1'b0, rib_e} + 7'd1) >= bh_eff;
  assign blk_done = {1'b0, cib_e} == (bw_eff - 7'd1);
  assign emit     = blk_ok && last_row && blk_done;
  assign rend     = (blk_lo == BLK_W'(OUT_SIZE - 1)) || (end_next > (PROD_W+1)'(w_eff));
  assign fend     = rend && (({1'b0, band_e} + 8'd1) >= 8'(OUT_SIZE));
  assign col_wrap = ({1'b0, col_e} + 13'd1) >= w_eff;

  assign accept = pix.valid && pix.ready;

  assign s_t       = {s_rem, s_sh[COL_W-1]};
  assign s_ge      = s_t >= bw_eff;
  assign s_rem_new = s_ge ? CIB_W'(s_t - bw_eff) : s_t[CIB_W-1:0];
  assign sync_last = s_cnt == SCNT_W'(COL_W - 1);

  assign u_sum = (u_zero ? '0 : mem_q) + SUM_W'(u_pix);

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (sync_req) begin
          state_next = F_SYNC;
        end else if (accept && blk_ok) begin
          state_next = F_UPD;
        end
      end
      F_SYNC: begin
        if (sync_last) begin
          state_next = F_IDLE;
        end
      end
      F_UPD: begin
        state_next = F_IDLE;
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_comb begin
    pix.ready  = 1'b0;
    sync_start = 1'b0;
    mem_rd     = 1'b0;
    mem_wr     = 1'b0;
    q_push     = 1'b0;
    case (state)
      F_IDLE: begin
        pix.ready  = !sync_req && !q_full;
        sync_start = sync_req;
        mem_rd     = accept && blk_ok;
      end
      F_UPD: begin
        mem_wr = !u_emit;
        q_push = u_emit;
      end
      default: begin
      end
    endcase
  end

  assign q_job = '{sum: u_sum, divisor: u_div, row_end: u_rend, frame_end: u_fend};

  always_comb begin
    pixel_column_next = pixel_column;
    row_in_band_next  = row_in_band;
    band_index_next   = band_index;
    frame_done_next   = frame_done;
    blk_next          = blk;
    cib_next          = cib;
    if (state == F_SYNC && sync_last) begin
      blk_next = {s_q[COL_W-2:0], s_ge};
      cib_next = s_rem_new;
    end
    if (accept) begin
      pixel_column_next = col_e;
      row_in_band_next  = rib_e;
      band_index_next   = band_e;
      frame_done_next   = fd_e;
      blk_next          = blk_e;
      cib_next          = cib_e;
      if (!fd_e) begin
        if (emit && fend) begin
          frame_done_next = 1'b1;
        end
        if (col_wrap) begin
          pixel_column_next = '0;
          blk_next          = '0;
          cib_next          = '0;
          if (last_row) begin
            row_in_band_next = '0;
            band_index_next  = band_inc;
            if ({1'b0, band_inc} >= 8'(OUT_SIZE)) begin
              frame_done_next = 1'b1;
            end
          end else begin
            row_in_band_next = rib_e + 6'd1;
          end
        end else begin
          pixel_column_next = col_e + 12'd1;
          if (blk_done) begin
            blk_next = blk_e + 12'd1;
            cib_next = '0;
          end else begin
            cib_next = cib_e + 6'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      pixel_column <= '0;
      row_in_band  <= '0;
      band_index   <= '0;
      frame_done   <= 1'b0;
      blk          <= '0;
      cib          <= '0;
      sync_req     <= 1'b0;
      valid        <= '0;
    end else begin
      state        <= state_next;
      pixel_column <= pixel_column_next;
      row_in_band  <= row_in_band_next;
      band_index   <= band_index_next;
      frame_done   <= frame_done_next;
      blk          <= blk_next;
      cib          <= cib_next;
      sync_req     <= resync || (sync_req && !sync_start);
      if (accept && fs) begin
        valid <= '0;
      end else if (mem_wr) begin
        valid[u_blk] <= 1'b1;
      end else if (q_push) begin
        valid[u_blk] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      u_blk  <= blk_lo;
      u_pix  <= pix.pixel;
      u_zero <= fs || !valid[blk_lo];
      u_emit <= emit;
      u_rend <= rend;
      u_fend <= fend;
      u_div  <= DIV_W'(div_prod);
    end
    if (sync_start) begin
      s_sh  <= pixel_column;
      s_q   <= '0;
      s_rem <= '0;
      s_cnt <= '0;
    end else if (state == F_SYNC) begin
      s_sh  <= s_sh << 1;
      s_q   <= {s_q[COL_W-2:0], s_ge};
      s_rem <= s_rem_new;
      s_cnt <= s_cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      mem_q <= sums[blk_lo];
    end
    if (mem_wr) begin
      sums[u_blk] <= u_sum;
    end
  end

endmodule

`default_nettype wire

// ----- design/bdas_queue.sv -----
`default_nettype none

module bdas_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bdas_pkg::job_t push_job,
  input  logic           pop,
  output bdas_pkg::job_t head,
  output logic           full,
  output logic           empty
);
  import bdas_pkg::*;

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head  = entries[rd_ptr];
  assign full  = count == QCNT_W'(QDEPTH);
  assign empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ----- design/bdas_back.sv -----
`default_nettype none

module bdas_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           invert,
  input  logic           q_empty,
  input  bdas_pkg::job_t q_job,
  output logic           q_pop,
  bdas_chr_if.source     chr
);
  import bdas_pkg::*;

  div_state_t state, state_next;

  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  dsh;
  logic [PIX_W-1:0]  quo;
  logic [2:0]        step;
  logic              rend;
  logic              fend;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_rend;
  logic              out_fend;

  logic              sat;
  logic              ge;
  logic              out_free;
  logic              out_load;
  logic [PIX_W-1:0]  avg;

  assign sat      = {1'b0, q_job.sum} >= {q_job.divisor, 8'b0};
  assign ge       = rem >= dsh;
  assign out_free = !out_valid || chr.ready;
  assign avg      = invert ? (PIX_MAX - quo) : quo;

  always_comb begin
    state_next = state;
    case (state)
      D_IDLE: begin
        if (!q_empty) begin
          state_next = sat ? D_DONE : D_RUN;
        end
      end
      D_RUN: begin
        if (step == 3'd7) begin
          state_next = D_DONE;
        end
      end
      D_DONE: begin
        if (out_free) begin
          state_next = D_IDLE;
        end
      end
      default: begin
        state_next = D_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state)
      D_IDLE: begin
        q_pop = !q_empty;
      end
      D_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= D_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (chr.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem  <= q_job.sum;
      dsh  <= {q_job.divisor, 7'b0};
      quo  <= sat ? PIX_MAX : '0;
      step <= '0;
      rend <= q_job.row_end;
      fend <= q_job.frame_end;
    end else if (state == D_RUN) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh  <= dsh >> 1;
      quo  <= {quo[PIX_W-2:0], ge};
      step <= step + 3'd1;
    end
    if (out_load) begin
      out_char <= shade_of(avg);
      out_rend <= rend;
      out_fend <= fend;
    end
  end

  assign chr.valid      = out_valid;
  assign chr.shade_char = out_char;
  assign chr.row_end    = out_rend;
  assign chr.frame_end  = out_fend;

endmodule

`default_nettype wire

// ----- design/box_downscale_ascii_shade.sv -----
// A block's last pixel is summed, queued, divided by the 8-step divider (skipped on
// saturation) and registered as its character; no new job starts before that load.
// Ignored pixels go one per cycle unless the queue is full or a resync is pending;
// in-grid pixels wait for the sum memory read then write. A 4-entry queue lets pixels
// run ahead. A block_w write holds off pixels during the 12-step column resync.
// Reset (synchronous, rst high) clears counters, sum valid bits, queue and output.
`default_nettype none

module box_downscale_ascii_shade (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [bdas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdas_pkg::CFG_DATA_W-1:0]    cfg_data,
  bdas_pix_if.sink                           pix,
  bdas_chr_if.source                         chr
);
  import bdas_pkg::*;

  cfg_t cfg;
  logic resync;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t head_job;

  assign resync = cfg_wr_en && (cfg_index == REG_BLOCK_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width <= RST_IMAGE_WIDTH;
      cfg.block_w     <= RST_BLOCK_W;
      cfg.block_h     <= RST_BLOCK_H;
      cfg.invert      <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: cfg.image_width <= cfg_data;
        REG_BLOCK_W:     cfg.block_w     <= cfg_data[BW_W-1:0];
        REG_BLOCK_H:     cfg.block_h     <= cfg_data[BW_W-1:0];
        REG_INVERT:      cfg.invert      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  bdas_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .resync (resync),
    .pix    (pix),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  bdas_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  bdas_back u_back (
    .clk     (clk),
    .rst     (rst),
    .invert  (cfg.invert),
    .q_empty (q_empty),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .chr     (chr)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_resync_holds: assert property (@(posedge clk) disable iff (rst) resync |=> !pix.ready)
    else $error("pixel taken before column resync");

endmodule

`default_nettype wire
